// File: sv/smoothed_gain_pan_stage_core_macros.svh
// ----------------------------------------------------------------------------
// smoothed gain / pan stage assertion macros
// Property wrappers on clk with rst_n low disabling the check.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_GAIN_PAN_STAGE_CORE_MACROS_SVH
`define SMOOTHED_GAIN_PAN_STAGE_CORE_MACROS_SVH

// same-cycle implication
`define SGP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sgp_pkg.sv
// ----------------------------------------------------------------------------
// sgp_pkg
// Shared constants, control structs and the exponent table builder.
// ----------------------------------------------------------------------------
package sgp_pkg;

    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int EXP_TABLE_BITS_DEF = 6;

    localparam int COEF           = 328;
    localparam int OCT_PER_DB_Q24 = 2786636;
    localparam int LN2_Q30        = 744261118;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_DB  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_MOD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAN_POS  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAN_MOD  = 2'd3;

    typedef struct packed {
        logic tgt;
        logic diff;
        logic mul;
        logic upd;
        logic oct;
        logic look;
        logic interp;
    } sgp_par_ctl_t;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_m;
        logic fin;
    } sgp_lane_ctl_t;

    // series terms vanish well before the last arm
    function automatic longint unsigned div_small(input longint unsigned v,
                                                  input int unsigned k);
        longint unsigned q;
        case (k)
            1:       q = v;
            2:       q = v / 64'd2;
            3:       q = v / 64'd3;
            4:       q = v / 64'd4;
            5:       q = v / 64'd5;
            6:       q = v / 64'd6;
            7:       q = v / 64'd7;
            8:       q = v / 64'd8;
            9:       q = v / 64'd9;
            10:      q = v / 64'd10;
            11:      q = v / 64'd11;
            12:      q = v / 64'd12;
            13:      q = v / 64'd13;
            14:      q = v / 64'd14;
            15:      q = v / 64'd15;
            16:      q = v / 64'd16;
            default: q = 64'd0;
        endcase
        return q;
    endfunction

    // 2^(i/2^tbits) in q2.30 by taylor series of exp
    function automatic logic [31:0] exp_entry(input int unsigned i,
                                              input int unsigned tbits);
        longint unsigned z;
        longint unsigned acc;
        longint unsigned term;
        int unsigned     k;
        z    = (64'(LN2_Q30) * 64'(i)) >> tbits;
        acc  = 64'd1 << 30;
        term = 64'd1 << 30;
        for (k = 1; k < 40; k++) begin
            if (term != 64'd0) begin
                term = div_small((term * z) >> 30, k);
                acc  = acc + term;
            end
        end
        return acc[31:0];
    endfunction

endpackage

// File: sv/smoothed_gain_pan_stage_core.sv
// ----------------------------------------------------------------------------
// smoothed_gain_pan_stage_core
// Smoothed dB gain and linear pan applied to one stereo sample pair per item.
//
//   channel | dir | handshake            | payload
//   s_*     | in  | s_tvalid / s_tready  | s_tdata: left_in, right_in
//   m_*     | out | m_tvalid / m_tready  | m_tdata: left_out, right_out
//   cfg_*   | in  | cfg_we               | cfg_idx, cfg_data
//
// an item is accepted, passes nine steps through the smoother, exponent table
// and lane multipliers, then moves into the output register once it is free;
// the smoother and exponent chain runs once per item and takes no new item
// until then; the output register frees the input side while a result waits
// reset clears smoother state (0 dB, center), the settings and the control state
// ----------------------------------------------------------------------------
`include "smoothed_gain_pan_stage_core_macros.svh"

module smoothed_gain_pan_stage_core #(
    parameter int SAMPLE_BITS    = sgp_pkg::SAMPLE_BITS_DEF,
    parameter int EXP_TABLE_BITS = sgp_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // left_in, right_in, zero pad
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // left_out, right_out, zero pad
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,
    input  logic                                     cfg_we,
    input  logic [sgp_pkg::CFG_IDX_BITS-1:0]         cfg_idx,
    input  logic [sgp_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

    localparam int STEPS    = 9;
    localparam int T_DIFF   = 0;
    localparam int T_MUL    = 1;
    localparam int T_UPD    = 2;
    localparam int T_OCT    = 3;
    localparam int T_LOOK   = 4;
    localparam int T_INTERP = 5;
    localparam int T_MUL_A  = 6;
    localparam int T_MUL_M  = 7;
    localparam int T_FIN    = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [STEPS-1:0]   token_reg, token_next;
    logic               accept;
    logic               out_load;

    logic signed [14:0] gain_db_reg;
    logic signed [15:0] gain_mod_reg;
    logic signed [15:0] pan_pos_reg;
    logic signed [15:0] pan_mod_reg;

    sgp_pkg::sgp_par_ctl_t  par_ctl;
    sgp_pkg::sgp_lane_ctl_t lane_ctl;

    logic [16:0]                   pan_l, pan_r;
    logic [31:0]                   mant;
    logic signed [7:0]             expo;
    logic signed [SAMPLE_BITS-1:0] left_res, right_res;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    always_comb
    begin
        state_next = state_reg;
        token_next = {token_reg[STEPS-2:0], 1'b0};
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    token_next[T_DIFF] = 1'b1;
                    state_next         = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (token_reg[T_FIN])
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_tvalid || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            token_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_db_reg  <= '0;
            gain_mod_reg <= '0;
            pan_pos_reg  <= '0;
            pan_mod_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                sgp_pkg::REG_GAIN_DB:  gain_db_reg  <= cfg_data[14:0];
                sgp_pkg::REG_GAIN_MOD: gain_mod_reg <= cfg_data;
                sgp_pkg::REG_PAN_POS:  pan_pos_reg  <= cfg_data;
                sgp_pkg::REG_PAN_MOD:  pan_mod_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign par_ctl.tgt    = accept;
    assign par_ctl.diff   = token_reg[T_DIFF];
    assign par_ctl.mul    = token_reg[T_MUL];
    assign par_ctl.upd    = token_reg[T_UPD];
    assign par_ctl.oct    = token_reg[T_OCT];
    assign par_ctl.look   = token_reg[T_LOOK];
    assign par_ctl.interp = token_reg[T_INTERP];

    assign lane_ctl.load  = accept;
    assign lane_ctl.mul_a = token_reg[T_MUL_A];
    assign lane_ctl.mul_m = token_reg[T_MUL_M];
    assign lane_ctl.fin   = token_reg[T_FIN];

    sgp_param #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_param (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (par_ctl),
        .gain_db  (gain_db_reg),
        .gain_mod (gain_mod_reg),
        .pan_pos  (pan_pos_reg),
        .pan_mod  (pan_mod_reg),
        .pan_l    (pan_l),
        .pan_r    (pan_r),
        .mant     (mant),
        .expo     (expo)
    );

    sgp_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .clk        (clk),
        .ctl        (lane_ctl),
        .sample_in  (s_tdata[SAMPLE_BITS-1:0]),
        .pan_gain   (pan_l),
        .mant       (mant),
        .expo       (expo),
        .sample_out (left_res)
    );

    sgp_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .clk        (clk),
        .ctl        (lane_ctl),
        .sample_in  (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .pan_gain   (pan_r),
        .mant       (mant),
        .expo       (expo),
        .sample_out (right_res)
    );

    sgp_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (out_load),
        .left   (left_res),
        .right  (right_res),
        .tvalid (m_tvalid),
        .tready (m_tready),
        .tdata  (m_tdata)
    );

    `SGP_ASSERT_IMPL(a_accept_idle, accept, token_reg == '0 && !out_load, "accept while busy")
    `SGP_ASSERT_IMPL(a_token_single, 1'b1, $onehot0(token_reg), "more than one step active")
    `SGP_ASSERT_IMPL(a_load_free, out_load, !m_tvalid || m_tready, "result overwrites untaken item")
    `SGP_ASSERT_NEXT(a_load_shown, out_load, m_tvalid, "loaded result not presented")

endmodule

// File: sv/sgp_param.sv
// ----------------------------------------------------------------------------
// sgp_param
// Gain and pan smoothers, dB to octave conversion and table interpolation.
// ----------------------------------------------------------------------------
module sgp_param #(
    parameter int EXP_TABLE_BITS = sgp_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sgp_pkg::sgp_par_ctl_t ctl,
    input  logic signed [14:0]   gain_db,
    input  logic signed [15:0]   gain_mod,
    input  logic signed [15:0]   pan_pos,
    input  logic signed [15:0]   pan_mod,
    output logic [16:0]          pan_l,
    output logic [16:0]          pan_r,
    output logic [31:0]          mant,
    output logic signed [7:0]    expo
);

    localparam int TBL_N = 1 << EXP_TABLE_BITS;
    localparam int RB    = 16 - EXP_TABLE_BITS;
    localparam logic signed [16:0] PAN_ONE  = 17'sd32768;
    localparam logic signed [16:0] PAN_MONE = -17'sd32768;

    logic [31:0] exp_tbl [TBL_N+1];

    for (genvar g = 0; g <= TBL_N; g++) begin : g_tbl
        localparam logic [31:0] ENTRY = sgp_pkg::exp_entry(g, EXP_TABLE_BITS);
        assign exp_tbl[g] = ENTRY;
    end

    logic signed [15:0]        tg_reg, tg_next;
    logic signed [16:0]        tp_reg, tp_next;
    logic signed [25:0]        gdiff_reg, gdiff_next;
    logic signed [32:0]        pdiff_reg, pdiff_next;
    logic signed [34:0]        gprod_reg, gprod_next;
    logic signed [41:0]        pprod_reg, pprod_next;
    logic signed [24:0]        sg_reg, sg_next;
    logic signed [31:0]        sp_reg, sp_next;
    logic signed [23:0]        x_reg, x_next;
    logic [16:0]               pl_reg, pl_next;
    logic [16:0]               pr_reg, pr_next;
    logic signed [7:0]         e_reg, e_next;
    logic [31:0]               base_reg, base_next;
    logic [31:0]               d0_reg, d0_next;
    logic [RB-1:0]             r_reg, r_next;
    logic [31:0]               m_reg, m_next;

    logic signed [21:0]        gmod60;
    logic signed [21:0]        gmod_sh;
    logic signed [16:0]        tp_sum;
    logic signed [34:0]        gstep;
    logic signed [41:0]        pstep;
    logic signed [47:0]        xprod;
    logic signed [16:0]        p_val;
    logic [EXP_TABLE_BITS-1:0] idx;
    logic [EXP_TABLE_BITS:0]   idx_lo, idx_hi;
    logic [RB+31:0]            dprod;

    always_comb
    begin
        gmod60  = 22'(gain_mod) * 22'sd60;
        gmod_sh = gmod60 >>> 7;
        tg_next = 16'(gain_db) + $signed(gmod_sh[15:0]);
        tp_sum  = 17'(pan_pos) + 17'(pan_mod);
        tp_next = (tp_sum > PAN_ONE) ? PAN_ONE : ((tp_sum < PAN_MONE) ? PAN_MONE : tp_sum);

        gdiff_next = 26'($signed({tg_reg, 8'd0})) - 26'(sg_reg);
        pdiff_next = 33'($signed({tp_reg, 15'd0})) - 33'(sp_reg);

        gprod_next = 35'(gdiff_reg) * 35'(sgp_pkg::COEF);
        pprod_next = 42'(pdiff_reg) * 42'(sgp_pkg::COEF);

        // round half up, then shift by 16
        gstep   = (gprod_reg + 35'sd32768) >>> 16;
        pstep   = (pprod_reg + 42'sd32768) >>> 16;
        sg_next = sg_reg + gstep[24:0];
        sp_next = sp_reg + pstep[31:0];

        xprod   = 48'(sg_reg) * 48'(sgp_pkg::OCT_PER_DB_Q24);
        x_next  = xprod[47:24];
        p_val   = sp_reg[31:15];
        pl_next = (p_val > 17'sd0) ? 17'(PAN_ONE - p_val) : 17'(PAN_ONE);
        pr_next = (p_val < 17'sd0) ? 17'(PAN_ONE + p_val) : 17'(PAN_ONE);

        e_next    = x_reg[23:16];
        idx       = x_reg[15 -: EXP_TABLE_BITS];
        idx_lo    = {1'b0, idx};
        idx_hi    = idx_lo + 1'b1;
        r_next    = x_reg[RB-1:0];
        base_next = exp_tbl[idx_lo];
        d0_next   = exp_tbl[idx_hi] - exp_tbl[idx_lo];

        dprod  = (RB+32)'(d0_reg) * (RB+32)'(r_reg);
        m_next = base_reg + dprod[RB+31:RB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg <= '0;
            sp_reg <= '0;
        end
        else if (ctl.upd)
        begin
            sg_reg <= sg_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.tgt)
        begin
            tg_reg <= tg_next;
            tp_reg <= tp_next;
        end
        if (ctl.diff)
        begin
            gdiff_reg <= gdiff_next;
            pdiff_reg <= pdiff_next;
        end
        if (ctl.mul)
        begin
            gprod_reg <= gprod_next;
            pprod_reg <= pprod_next;
        end
        if (ctl.oct)
        begin
            x_reg  <= x_next;
            pl_reg <= pl_next;
            pr_reg <= pr_next;
        end
        if (ctl.look)
        begin
            e_reg    <= e_next;
            base_reg <= base_next;
            d0_reg   <= d0_next;
            r_reg    <= r_next;
        end
        if (ctl.interp)
        begin
            m_reg <= m_next;
        end
    end

    assign pan_l = pl_reg;
    assign pan_r = pr_reg;
    assign mant  = m_reg;
    assign expo  = e_reg;

endmodule

// File: sv/sgp_lane.sv
// ----------------------------------------------------------------------------
// sgp_lane
// One channel: pan scaling, gain mantissa multiply, exponent shift, saturation.
// ----------------------------------------------------------------------------
module sgp_lane #(
    parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  sgp_pkg::sgp_lane_ctl_t         ctl,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [16:0]                   pan_gain,
    input  logic [31:0]                   mant,
    input  logic signed [7:0]             expo,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int AW = SAMPLE_BITS + 18;
    localparam int MW = SAMPLE_BITS + 33;
    localparam logic signed [65:0] SAT_HI = (66'sd1 <<< (SAMPLE_BITS - 1)) - 66'sd1;
    localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

    logic signed [SAMPLE_BITS-1:0] samp_reg;
    logic signed [SAMPLE_BITS-1:0] a_reg, a_next;
    logic signed [MW-1:0]          am_reg, am_next;
    logic signed [SAMPLE_BITS-1:0] out_reg, out_next;

    logic signed [AW-1:0] pa;
    logic signed [AW-1:0] pa_rnd;
    logic signed [8:0]    sh_raw;
    logic [5:0]           sh;
    logic signed [65:0]   rnd66;
    logic signed [65:0]   sum66;
    logic signed [65:0]   v66;

    always_comb
    begin
        pa     = AW'(samp_reg) * AW'($signed({1'b0, pan_gain}));
        pa_rnd = (pa + AW'(16384)) >>> 15;
        a_next = pa_rnd[SAMPLE_BITS-1:0];

        am_next = MW'(a_reg) * MW'($signed({1'b0, mant}));

        sh_raw = 9'sd30 - 9'(expo);
        if (sh_raw < 9'sd1)
            sh = 6'd1;
        else if (sh_raw > 9'sd62)
            sh = 6'd62;
        else
            sh = sh_raw[5:0];
        rnd66 = 66'sd1 <<< (sh - 6'd1);
        sum66 = 66'(am_reg) + rnd66;
        v66   = sum66 >>> sh;
        if (v66 > SAT_HI)
            out_next = SAT_HI[SAMPLE_BITS-1:0];
        else if (v66 < SAT_LO)
            out_next = SAT_LO[SAMPLE_BITS-1:0];
        else
            out_next = v66[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            samp_reg <= sample_in;
        if (ctl.mul_a)
            a_reg <= a_next;
        if (ctl.mul_m)
            am_reg <= am_next;
        if (ctl.fin)
            out_reg <= out_next;
    end

    assign sample_out = out_reg;

endmodule

// File: sv/sgp_merge.sv
// ----------------------------------------------------------------------------
// sgp_merge
// Joins the two lane results into one output item and holds it until taken.
// ----------------------------------------------------------------------------
module sgp_merge #(
    parameter int SAMPLE_BITS = sgp_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  logic [SAMPLE_BITS-1:0]                     left,
    input  logic [SAMPLE_BITS-1:0]                     right,
    output logic                                       tvalid,
    input  logic                                       tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]         tdata
);

    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic             valid_reg;
    logic [OUT_W-1:0] data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= OUT_W'({right, left});
    end

    assign tvalid = valid_reg;
    assign tdata  = data_reg;

endmodule

// File: dv/tb_smoothed_gain_pan_stage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_smoothed_gain_pan_stage_core
// Streams stereo sample pairs through the smoothed gain / pan stage and
// checks every output pair against a cycle-free predictor of the smoothers,
// the dB-to-linear exponent table and the per-lane saturating scaling.
// Covers reset defaults, register extremes, a long hard-left pan run, random settings,
// output backpressure and a final gapless stream.
// ----------------------------------------------------------------------------
module tb_smoothed_gain_pan_stage_core;

    localparam int SB             = sgp_pkg::SAMPLE_BITS_DEF;
    localparam int TBITS          = sgp_pkg::EXP_TABLE_BITS_DEF;
    localparam int TBL_N          = 1 << TBITS;
    localparam int DATA_W         = ((2 * SB + 7) / 8) * 8;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int COEF           = sgp_pkg::COEF;
    localparam int OCT_PER_DB_Q24 = sgp_pkg::OCT_PER_DB_Q24;
    localparam int LN2_Q30        = sgp_pkg::LN2_Q30;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [SB-1:0] right;
        logic [SB-1:0] left;
    } stereo_t;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [DATA_W-1:0]                 s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [DATA_W-1:0]                 m_tdata;
    logic                              cfg_we;
    logic [sgp_pkg::CFG_IDX_BITS-1:0]  cfg_idx;
    logic [sgp_pkg::CFG_DATA_BITS-1:0] cfg_data;

    logic signed [14:0] gain_db_r;
    logic signed [15:0] gain_mod_r;
    logic signed [15:0] pan_pos_r;
    logic signed [15:0] pan_mod_r;
    longint             sm_gain_db;
    longint             sm_pan;
    longint             pow2_frac [0:TBL_N];

    stereo_t pending_pairs [$];
    int      err_cnt;
    int      cycle_cnt;
    int      hold_req;
    bit      src_idle_en;
    bit      snk_idle_en;

    smoothed_gain_pan_stage_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("smoothed_gain_pan_stage_core verification failed");
            $finish;
        end
    end

    // 2^(i/N) in q2.30, taylor series of exp with floor at each step
    function automatic void fill_pow2_frac();
        u64_t z;
        u64_t acc;
        u64_t term;
        for (int i = 0; i <= TBL_N; i++)
        begin
            z    = (u64_t'(LN2_Q30) * u64_t'(i)) >> TBITS;
            acc  = u64_t'(1) << 30;
            term = acc;
            for (int k = 1; k < 40 && term != 0; k++)
            begin
                term = ((term * z) >> 30) / u64_t'(k);
                acc  = acc + term;
            end
            pow2_frac[i] = longint'(acc);
        end
    endfunction

    function automatic void predictor_reset();
        gain_db_r  = '0;
        gain_mod_r = '0;
        pan_pos_r  = '0;
        pan_mod_r  = '0;
        sm_gain_db = 0;
        sm_pan     = 0;
        fill_pow2_frac();
    endfunction

    function automatic logic [SB-1:0] lane_scale(input logic signed [SB-1:0] smp,
                                                 input longint pan_w, mant,
                                                 input int ex);
        longint att;
        longint v;
        longint hi;
        longint lo;
        int     sh;
        att = (longint'(smp) * pan_w + 64'sd16384) >>> 15;
        sh  = 30 - ex;
        if (sh < 1)
            sh = 1;
        if (sh > 62)
            sh = 62;
        v  = (att * mant + (64'sd1 <<< (sh - 1))) >>> sh;
        hi = (64'sd1 <<< (SB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[SB-1:0];
    endfunction

    // advances both smoothers by one item and scales the pair
    function automatic stereo_t gain_pan_predict(input stereo_t smp);
        longint  tgt_db;
        longint  tgt_pan;
        longint  pan_q15;
        longint  pan_l;
        longint  pan_r;
        longint  oct;
        longint  frac;
        longint  idx;
        longint  rem;
        longint  mant;
        int      ex;
        stereo_t res;
        tgt_db  = longint'(gain_db_r) + ((longint'(gain_mod_r) * 60) >>> 7);
        tgt_pan = longint'(pan_pos_r) + longint'(pan_mod_r);
        if (tgt_pan > 32768)
            tgt_pan = 32768;
        if (tgt_pan < -32768)
            tgt_pan = -32768;
        sm_gain_db = sm_gain_db + (((tgt_db * 256 - sm_gain_db) * COEF + 32768) >>> 16);
        sm_pan     = sm_pan + (((tgt_pan * 32768 - sm_pan) * COEF + 32768) >>> 16);

        pan_q15 = sm_pan >>> 15;
        if (pan_q15 > 32768)
            pan_q15 = 32768;
        if (pan_q15 < -32768)
            pan_q15 = -32768;
        pan_l = 32768 - pan_q15;
        if (pan_l > 32768)
            pan_l = 32768;
        pan_r = 32768 + pan_q15;
        if (pan_r > 32768)
            pan_r = 32768;

        oct  = (sm_gain_db * OCT_PER_DB_Q24) >>> 24;
        ex   = int'(oct >>> 16);
        frac = oct & 64'hFFFF;
        idx  = frac >>> (16 - TBITS);
        rem  = frac & ((64'sd1 <<< (16 - TBITS)) - 1);
        mant = pow2_frac[idx]
             + (((pow2_frac[idx + 1] - pow2_frac[idx]) * rem) >>> (16 - TBITS));

        res.left  = lane_scale(smp.left, pan_l, mant, ex);
        res.right = lane_scale(smp.right, pan_r, mant, ex);
        return res;
    endfunction

    always @(posedge clk)
    begin : accept_monitor
        if (rst_n && s_tvalid && s_tready)
            pending_pairs.push_back(gain_pan_predict(stereo_t'(s_tdata[2*SB-1:0])));
    end

    always @(posedge clk)
    begin : result_check
        stereo_t got;
        stereo_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = stereo_t'(m_tdata[2*SB-1:0]);
            if (pending_pairs.size() == 0)
            begin
                $error("unexpected item: left_out %0d right_out %0d",
                       $signed(got.left), $signed(got.right));
                err_cnt++;
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got.left !== want.left)
                begin
                    $error("left_out mismatch: expected %0d, got %0d",
                           $signed(want.left), $signed(got.left));
                    err_cnt++;
                end
                if (got.right !== want.right)
                begin
                    $error("right_out mismatch: expected %0d, got %0d",
                           $signed(want.right), $signed(got.right));
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin : sink_ready
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (snk_idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_pair(input stereo_t v);
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(v);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering, wait out every result, then the block latency
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pairs.size() != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] g, gm, pp, pm);
        cfg_we   <= 1'b1;
        cfg_idx  <= sgp_pkg::REG_GAIN_DB;
        cfg_data <= g;
        @(posedge clk);
        cfg_idx  <= sgp_pkg::REG_GAIN_MOD;
        cfg_data <= gm;
        @(posedge clk);
        cfg_idx  <= sgp_pkg::REG_PAN_POS;
        cfg_data <= pp;
        @(posedge clk);
        cfg_idx  <= sgp_pkg::REG_PAN_MOD;
        cfg_data <= pm;
        @(posedge clk);
        cfg_we     <= 1'b0;
        gain_db_r  = g[14:0];
        gain_mod_r = gm;
        pan_pos_r  = pp;
        pan_mod_r  = pm;
    endtask

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_regs(input bit hard_left);
        logic [15:0] g;
        logic [15:0] gm;
        logic [15:0] pp;
        logic [15:0] pm;
        case ($urandom_range(0, 5))
            0:       g = 16'($urandom);
            1:       g = 16'h3FFF;
            2:       g = 16'h4000;
            default: g = 16'($urandom_range(0, 18432) - 15360);
        endcase
        g[15] = 1'($urandom);
        gm    = pick_q15();
        pp    = pick_q15();
        pm    = pick_q15();
        // both nonpositive with one at -1 keeps the target at the left end
        if (hard_left)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pp = 16'h8000;
                pm = 16'(-int'($urandom_range(0, 32768)));
            end
            else
            begin
                pm = 16'h8000;
                pp = 16'(-int'($urandom_range(0, 32768)));
            end
        end
        write_regs(g, gm, pp, pm);
    endtask

    task automatic send_random(input int n);
        stereo_t v;
        repeat (n)
        begin
            v.left  = pick_sample();
            v.right = pick_sample();
            send_pair(v);
        end
    endtask

    task automatic send_extreme_set();
        send_pair('{right: {1'b1, {(SB-1){1'b0}}}, left: {1'b0, {(SB-1){1'b1}}}});
        send_pair('{right: {1'b0, {(SB-1){1'b1}}}, left: {1'b1, {(SB-1){1'b0}}}});
        send_pair('{right: '1, left: '0});
        send_pair('{right: SB'(1), left: '1});
        send_pair('{right: {(SB/2){2'b10}}, left: {(SB/2){2'b01}}});
        send_pair('{right: {(SB/2){2'b01}}, left: {(SB/2){2'b10}}});
        send_pair('{right: {1'b0, {(SB-1){1'b1}}}, left: {1'b0, {(SB-1){1'b1}}}});
        send_pair('{right: {1'b1, {(SB-1){1'b0}}}, left: {1'b1, {(SB-1){1'b0}}}});
    endtask

    task automatic test_reset_defaults();
        send_pair('{right: {1'b1, {(SB-1){1'b0}}}, left: {1'b0, {(SB-1){1'b1}}}});
        send_pair('{right: {1'b0, {(SB-1){1'b1}}}, left: {1'b1, {(SB-1){1'b0}}}});
        send_pair('{right: '1, left: '0});
        send_pair('{right: {(SB/2){2'b10}}, left: {(SB/2){2'b01}}});
        settle();
    endtask

    // top gain with the unused gain bit set and pan clamped high, then the bottom
    task automatic test_gain_pan_extremes();
        write_regs(16'hBFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_extreme_set();
        settle();
        write_regs(16'h4000, 16'h8000, 16'h8000, 16'h8000);
        send_extreme_set();
        settle();
    endtask

    // pan target held at the left end across several random settings
    task automatic test_hard_left_pan();
        for (int ph = 0; ph < 8; ph++)
        begin
            random_regs(1'b1);
            send_random(70);
            settle();
        end
    endtask

    task automatic test_random_settings();
        for (int ph = 0; ph < 5; ph++)
        begin
            random_regs(1'b0);
            send_random(80);
            settle();
        end
    endtask

    task automatic test_output_backpressure();
        random_regs(1'b0);
        src_idle_en = 1'b0;
        hold_req    = 300;
        send_random(12);
        src_idle_en = 1'b1;
        settle();
    endtask

    task automatic test_steady_stream();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        random_regs(1'b0);
        send_random(150);
        settle();
    endtask

    initial
    begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        cfg_we      <= 1'b0;
        cfg_idx     <= sgp_pkg::REG_GAIN_DB;
        cfg_data    <= '0;
        rst_n       <= 1'b0;
        cycle_cnt   = 0;
        err_cnt     = 0;
        hold_req    = 0;
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        predictor_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_gain_pan_extremes();
        test_hard_left_pan();
        test_random_settings();
        test_output_backpressure();
        test_steady_stream();

        repeat (20) @(posedge clk);
        if (err_cnt == 0 && pending_pairs.size() == 0)
            $display("smoothed_gain_pan_stage_core verification clean");
        else
            $display("smoothed_gain_pan_stage_core verification failed");
        $finish;
    end

endmodule
